/* src/flvtr_pkg.sv */
// Shared types and constants for the FLV tag timestamp rebase unit.
package flvtr_pkg;

   // Byte and timestamp widths fixed by the FLV format.
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned TS_W        = 24;
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned COUNT_W     = 2;

   // Configuration port layout: two 24-bit registers at word addresses.
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic        CSR_IDX_VIDEO_OFFSET = 1'b0;
   localparam logic        CSR_IDX_AUDIO_OFFSET = 1'b1;

   // Bytes produced for one accepted input byte, first to leave in slot zero.
   typedef struct packed {
      logic [COUNT_W-1:0]                  count;
      logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
   } result_type;

endpackage

/* src/flvtr_parser.sv */
// Byte-wise FLV parser that tracks header, tag and body position and rebases timestamps.
module flvtr_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [flvtr_pkg::BYTE_W-1:0]          data_byte,
   input  logic                                   file_start,
   input  logic [flvtr_pkg::TS_W-1:0]            video_offset,
   input  logic [flvtr_pkg::TS_W-1:0]            audio_offset,
   output flvtr_pkg::result_type                  result
);

   typedef enum logic [1:0] {
      PH_SKIP = 2'd0,
      PH_TAG  = 2'd1,
      PH_BODY = 2'd2,
      PH_SPARE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_AUDIO  = 2'd0,
      KIND_VIDEO  = 2'd1,
      KIND_SCRIPT = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   localparam logic [4:0] TYPE_SCRIPT    = 5'd18;
   localparam logic [4:0] TYPE_VIDEO     = 5'd9;
   localparam logic [3:0] FILE_HDR_LEN   = 4'd13;
   localparam logic [3:0] POS_SIZE_FIRST = 4'd1;
   localparam logic [3:0] POS_SIZE_LAST  = 4'd3;
   localparam logic [3:0] POS_TS_HIGH    = 4'd4;
   localparam logic [3:0] POS_TS_MID     = 4'd5;
   localparam logic [3:0] POS_TS_LOW     = 4'd6;
   localparam logic [3:0] POS_HDR_LAST   = 4'd10;
   localparam logic [24:0] PREV_SIZE_LEN = 25'd4;

   phase_type    phase_ff,  phase_in;
   logic [3:0]   pos_ff,    pos_in;
   kind_type     kind_ff,   kind_in;
   logic [23:0]  size_ff,   size_in;
   logic [24:0]  remain_ff, remain_in;
   logic [15:0]  held_ff,   held_in;

   phase_type    phase_cur;
   logic [3:0]   pos_cur;
   logic [3:0]   pos_inc;
   logic [24:0]  remain_dec;
   logic [23:0]  ts_full;
   logic [23:0]  ts_sum;

   // A file start restarts header skipping whatever the tracked position.
   // The kind only changes on the type byte, so the stored kind serves the low timestamp byte.
   assign phase_cur  = file_start ? PH_SKIP : phase_ff;
   assign pos_cur    = file_start ? 4'd0 : pos_ff;
   assign pos_inc    = pos_cur + 4'd1;
   assign remain_dec = remain_ff - 25'd1;
   assign ts_full    = {held_ff, data_byte};
   assign ts_sum     = ts_full + ((kind_ff == KIND_VIDEO) ? video_offset : audio_offset);

   // Next state and the result bytes for the byte on the input.
   always_comb begin
      phase_in  = phase_cur;
      pos_in    = pos_cur;
      kind_in   = kind_ff;
      size_in   = size_ff;
      remain_in = remain_ff;
      held_in   = held_ff;
      result.count = 2'd0;
      result.data  = {data_byte, data_byte, data_byte};
      case (phase_cur)
         PH_SKIP: begin
            pos_in = pos_inc;
            if (pos_inc >= FILE_HDR_LEN) begin
               phase_in = PH_TAG;
               pos_in   = 4'd0;
            end
         end
         PH_BODY: begin
            if (kind_ff != KIND_SCRIPT) begin
               result.count = 2'd1;
            end
            remain_in = remain_dec;
            if (remain_dec == 25'd0) begin
               phase_in = PH_TAG;
               pos_in   = 4'd0;
            end
         end
         default: begin
            // Tag header, also taken for the phase code that never arises.
            if (pos_cur == 4'd0) begin
               if (data_byte[4:0] == TYPE_SCRIPT) begin
                  kind_in = KIND_SCRIPT;
               end else if (data_byte[4:0] == TYPE_VIDEO) begin
                  kind_in = KIND_VIDEO;
               end else begin
                  kind_in = KIND_AUDIO;
               end
               size_in = 24'd0;
            end else if (pos_cur >= POS_SIZE_FIRST && pos_cur <= POS_SIZE_LAST) begin
               size_in = {size_ff[15:0], data_byte};
            end
            if (kind_in == KIND_SCRIPT) begin
               result.count = 2'd0;
            end else if (pos_cur == POS_TS_HIGH) begin
               held_in = {data_byte, 8'd0};
            end else if (pos_cur == POS_TS_MID) begin
               held_in = {held_ff[15:8], data_byte};
            end else if (pos_cur == POS_TS_LOW) begin
               result.count = 2'd3;
               result.data  = {ts_sum[7:0], ts_sum[15:8], ts_sum[23:16]};
            end else begin
               result.count = 2'd1;
            end
            if (pos_cur >= POS_HDR_LAST) begin
               remain_in = {1'b0, size_in} + PREV_SIZE_LEN;
               phase_in  = PH_BODY;
               pos_in    = 4'd0;
            end else begin
               pos_in   = pos_inc;
               phase_in = PH_TAG;
            end
         end
      endcase
   end

   // Parser state advances only on an accepted input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SKIP;
         pos_ff    <= 4'd0;
         kind_ff   <= KIND_AUDIO;
         size_ff   <= 24'd0;
         remain_ff <= 25'd0;
         held_ff   <= 16'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         kind_ff   <= kind_in;
         size_ff   <= size_in;
         remain_ff <= remain_in;
         held_ff   <= held_in;
      end
   end

endmodule

/* src/flvtr_outbuf.sv */
// Holds up to three result bytes of one input, sent one a cycle while rsp_tready is high.
module flvtr_outbuf (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  flvtr_pkg::result_type               result,
   output logic                                can_load,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [flvtr_pkg::BYTE_W-1:0]       rsp_tdata,
   output logic                                rsp_tlast
);

   logic [flvtr_pkg::COUNT_W-1:0]                            count_ff, count_in;
   logic [flvtr_pkg::MAX_RESULTS-1:0][flvtr_pkg::BYTE_W-1:0] data_ff,  data_in;
   logic                                                     pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = (count_ff == 2'd1);
   assign pop        = rsp_tvalid && rsp_tready;
   // A new input may enter once the register is empty or its last byte leaves now.
   assign can_load   = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_tready);

   // Load a fresh run, or shift the next byte of the current run forward.
   always_comb begin
      count_in = count_ff;
      data_in  = data_ff;
      if (load) begin
         count_in = result.count;
         data_in  = result.data;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         data_in  = {data_ff[2], data_ff[2], data_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* src/flv_tag_timestamp_rebase_unit.sv */
// Top level of the FLV tag timestamp rebase unit: register port, parser and result register.
//
//   Channel   Direction   Carries                                      Transfer when
//   req_      in          tdata: data_byte; tuser: file_start           tvalid && tready
//   rsp_      out         tdata: out_byte; tlast: last_of_run           tvalid && tready
//   csr_      in/out      video_offset at 0x0, audio_offset at 0x4     psel&penable&pwrite
//
// Results are registered and presented the cycle after their input byte is taken.
// Bytes that pass through run at one byte a cycle while rsp_tready is high; the low
// timestamp byte yields three bytes and holds req_tready low while the result register
// drains. Skipped and dropped bytes are taken every cycle once that register is empty.
// Reset is synchronous; it puts the parser into file header skipping, offsets at zero.
// A stall on rsp_tready stalls req_tready in the same cycle through the result register.
module flv_tag_timestamp_rebase_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [flvtr_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] data_byte
   input  logic                                  req_tuser,   // [0] file_start
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [flvtr_pkg::BYTE_W-1:0]         rsp_tdata,   // [7:0] out_byte
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [flvtr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [flvtr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [flvtr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   logic [flvtr_pkg::TS_W-1:0] video_offset_ff;
   logic [flvtr_pkg::TS_W-1:0] audio_offset_ff;
   logic                       csr_write;
   logic                       csr_index;
   logic                       req_accept;
   logic                       can_load;
   flvtr_pkg::result_type      result;

   // Register port: always ready, word index taken from address bit two.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_index)
         flvtr_pkg::CSR_IDX_VIDEO_OFFSET: csr_prdata = {8'd0, video_offset_ff};
         flvtr_pkg::CSR_IDX_AUDIO_OFFSET: csr_prdata = {8'd0, audio_offset_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         video_offset_ff <= '0;
         audio_offset_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == flvtr_pkg::CSR_IDX_VIDEO_OFFSET) begin
            video_offset_ff <= csr_pwdata[flvtr_pkg::TS_W-1:0];
         end else begin
            audio_offset_ff <= csr_pwdata[flvtr_pkg::TS_W-1:0];
         end
      end
   end

   // Input transfer handshake.
   assign req_tready = can_load;
   assign req_accept = req_tvalid && req_tready;

   flvtr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_tdata),
      .file_start   (req_tuser),
      .video_offset (video_offset_ff),
      .audio_offset (audio_offset_ff),
      .result       (result)
   );

   flvtr_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A file start byte is always skipped, so nothing is left waiting after it.
   a_start_leaves_empty: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> !rsp_tvalid)
      else $error("result pending after a file start transfer");

   // A run of timestamp bytes continues without a gap until its last byte.
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("result run broken before its last byte");

   // Input is only taken when at most the final byte of a run is still held.
   a_ready_only_near_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tlast))
      else $error("input taken while several result bytes are pending");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the FLV tag timestamp rebase unit.
module tb;

   // Stream layout and timing.
   localparam int unsigned FILE_HDR_LEN  = 13;
   localparam int unsigned TAG_HDR_LAST  = 10;
   localparam int unsigned PREV_SIZE_LEN = 4;
   localparam int unsigned PHASE_BYTES   = 50;
   localparam int unsigned IDLE_PERCENT  = 21;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned END_CYCLES    = 10;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned REPORT_LIMIT  = 10;

   // Tag type codes (low five bits of the first tag header byte).
   localparam logic [4:0] TYPE_VIDEO  = 5'd9;
   localparam logic [4:0] TYPE_SCRIPT = 5'd18;
   localparam logic [23:0] TS_MAX     = 24'hFFFFFF;

   // Register addresses derived from the register indexes.
   localparam logic [flvtr_pkg::CSR_ADDR_W-1:0] ADDR_VIDEO_OFFSET =
      {flvtr_pkg::CSR_IDX_VIDEO_OFFSET, 2'b00};
   localparam logic [flvtr_pkg::CSR_ADDR_W-1:0] ADDR_AUDIO_OFFSET =
      {flvtr_pkg::CSR_IDX_AUDIO_OFFSET, 2'b00};

   typedef enum logic [1:0] {
      PARSE_SKIP = 2'd0,
      PARSE_TAG  = 2'd1,
      PARSE_BODY = 2'd2
   } parse_phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER  = 2'd0,
      KIND_VIDEO  = 2'd1,
      KIND_SCRIPT = 2'd2
   } tag_kind_type;

   typedef struct packed {
      logic [flvtr_pkg::BYTE_W-1:0] data;
      logic                         start;
   } source_byte_type;

   typedef struct packed {
      logic [flvtr_pkg::BYTE_W-1:0] value;
      logic                         last;
   } rebased_byte_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [flvtr_pkg::BYTE_W-1:0]     req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [flvtr_pkg::BYTE_W-1:0]     rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [flvtr_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [flvtr_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [flvtr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   flv_tag_timestamp_rebase_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Stimulus and expectation stores.
   source_byte_type  pending_bytes[$];
   rebased_byte_type rebased_stream[$];
   source_byte_type  next_byte;
   rebased_byte_type expected_byte;
   int unsigned      fail_count   = 0;
   int unsigned      cycle_count  = 0;
   int unsigned      stream_bytes = 0;
   logic             steady       = 1'b0;

   // Shadow of the parser state and the offsets.
   parse_phase_type shadow_phase   = PARSE_SKIP;
   logic [3:0]      shadow_pos     = '0;
   tag_kind_type    shadow_kind    = KIND_OTHER;
   logic [23:0]     shadow_size    = '0;
   logic [24:0]     shadow_left    = '0;
   logic [15:0]     shadow_ts_hold = '0;
   logic [23:0]     video_ofs      = '0;
   logic [23:0]     audio_ofs      = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the rewritten bytes that one accepted source byte gives.
   function automatic void rebase_predict(input logic [7:0] b, input logic start);
      logic [3:0]  pos;
      logic [23:0] sum;
      if (start) begin
         shadow_phase = PARSE_SKIP;
         shadow_pos   = '0;
      end
      case (shadow_phase)
         PARSE_SKIP: begin
            shadow_pos = shadow_pos + 4'd1;
            if (shadow_pos >= FILE_HDR_LEN) begin
               shadow_phase = PARSE_TAG;
               shadow_pos   = '0;
            end
         end
         PARSE_BODY: begin
            if (shadow_kind != KIND_SCRIPT)
               rebased_stream.push_back('{value: b, last: 1'b1});
            shadow_left = shadow_left - 25'd1;
            if (shadow_left == '0) begin
               shadow_phase = PARSE_TAG;
               shadow_pos   = '0;
            end
         end
         default: begin
            pos = shadow_pos;
            if (pos == 4'd0) begin
               if (b[4:0] == TYPE_SCRIPT)
                  shadow_kind = KIND_SCRIPT;
               else if (b[4:0] == TYPE_VIDEO)
                  shadow_kind = KIND_VIDEO;
               else
                  shadow_kind = KIND_OTHER;
               shadow_size = '0;
            end else if (pos <= 4'd3) begin
               shadow_size = {shadow_size[15:0], b};
            end
            // Script tags emit nothing; the timestamp is held until its low byte.
            if (shadow_kind == KIND_SCRIPT) begin
            end else if (pos == 4'd4) begin
               shadow_ts_hold = {b, 8'h00};
            end else if (pos == 4'd5) begin
               shadow_ts_hold[7:0] = b;
            end else if (pos == 4'd6) begin
               sum = {shadow_ts_hold, b} +
                     ((shadow_kind == KIND_VIDEO) ? video_ofs : audio_ofs);
               rebased_stream.push_back('{value: sum[23:16], last: 1'b0});
               rebased_stream.push_back('{value: sum[15:8],  last: 1'b0});
               rebased_stream.push_back('{value: sum[7:0],   last: 1'b1});
            end else begin
               rebased_stream.push_back('{value: b, last: 1'b1});
            end
            if (pos >= TAG_HDR_LAST) begin
               shadow_left  = {1'b0, shadow_size} + 25'd4;
               shadow_phase = PARSE_BODY;
               shadow_pos   = '0;
            end else begin
               shadow_pos   = pos + 4'd1;
               shadow_phase = PARSE_TAG;
            end
         end
      endcase
   endfunction

   // Source side: presents queued bytes, records each accepted transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            rebase_predict(req_tdata, req_tuser);
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               next_byte = pending_bytes.pop_front();
               req_tdata  <= next_byte.data;
               req_tuser  <= next_byte.start;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: random back-pressure and comparison against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rebased_stream.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected result: byte %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               expected_byte = rebased_stream.pop_front();
               if (rsp_tdata !== expected_byte.value || rsp_tlast !== expected_byte.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("mismatch: expected byte %h last %b, got byte %h last %b",
                              expected_byte.value, expected_byte.last, rsp_tdata, rsp_tlast);
               end
            end
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] data, input logic start);
      pending_bytes.push_back('{data: data, start: start});
      stream_bytes++;
   endtask

   task automatic add_file_header();
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (FILE_HDR_LEN - 1) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // One complete tag: header, body and previous-size field.
   task automatic add_tag(input logic [4:0] tag_type, input logic [23:0] size,
                          input logic [23:0] ts);
      logic [2:0] upper;
      upper = 3'($urandom_range(0, 7));
      push_byte({upper, tag_type}, 1'b0);
      push_byte(size[23:16], 1'b0);
      push_byte(size[15:8], 1'b0);
      push_byte(size[7:0], 1'b0);
      push_byte(ts[23:16], 1'b0);
      push_byte(ts[15:8], 1'b0);
      push_byte(ts[7:0], 1'b0);
      repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0);
      repeat (size) push_byte(8'($urandom_range(0, 255)), 1'b0);
      repeat (PREV_SIZE_LEN) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Mostly well-formed tags; the rest are tags cut short by a new file.
   task automatic add_random_tag();
      int unsigned r;
      int unsigned cut;
      logic [4:0]  tag_type;
      logic [23:0] size;
      logic [23:0] ts;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
         0:       ts = TS_MAX;
         1:       ts = '0;
         default: ts = 24'($urandom());
      endcase
      size = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(7, 40))
                                         : 24'($urandom_range(0, 6));
      if (r < 90) begin
         if (r < 40) begin
            tag_type = TYPE_VIDEO;
         end else if (r < 60) begin
            tag_type = TYPE_SCRIPT;
         end else begin
            case ($urandom_range(0, 3))
               0:       tag_type = 5'd0;
               1:       tag_type = 5'd31;
               default: begin
                  do tag_type = 5'($urandom_range(0, 31));
                  while (tag_type == TYPE_VIDEO || tag_type == TYPE_SCRIPT);
               end
            endcase
         end
         add_tag(tag_type, size, ts);
      end else begin
         // Broken tag of random bytes cut short, then a restart.
         cut = $urandom_range(1, 14);
         repeat (cut) push_byte(8'($urandom_range(0, 255)), 1'b0);
         if ($urandom_range(0, 1)) begin
            push_byte(8'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         add_file_header();
      end
   endtask

   task automatic wait_drained(input int unsigned extra);
      while (pending_bytes.size() != 0 || req_tvalid || rebased_stream.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(input logic [flvtr_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [23:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {8'($urandom_range(0, 255)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_offsets(input logic [23:0] video, input logic [23:0] audio);
      csr_write(ADDR_VIDEO_OFFSET, video);
      video_ofs = video;
      csr_write(ADDR_AUDIO_OFFSET, audio);
      audio_ofs = audio;
   endtask

   task automatic run_random_phase(input logic [23:0] video, input logic [23:0] audio,
                                   input logic no_idle);
      wait_drained(SETTLE_CYCLES);
      set_offsets(video, audio);
      steady = no_idle;
      stream_bytes = 0;
      while (stream_bytes < PHASE_BYTES) add_random_tag();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: header of extreme bytes, then an empty video tag with the largest
      // timestamp and offsets still at their reset value.
      push_byte(8'h00, 1'b1);
      repeat (6) begin
         push_byte(8'hFF, 1'b0);
         push_byte(8'h00, 1'b0);
      end
      push_byte({3'b111, TYPE_VIDEO}, 1'b0);
      repeat (3) push_byte(8'h00, 1'b0);
      repeat (3) push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      repeat (3) push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);

      // Random phases over several offset settings, the extremes among them.
      run_random_phase(TS_MAX, TS_MAX, 1'b0);
      run_random_phase(24'd0, 24'd1, 1'b0);
      run_random_phase(24'($urandom()), 24'($urandom()), 1'b1);
      run_random_phase(24'd1, TS_MAX, 1'b0);

      wait_drained(END_CYCLES);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
